FILE: rtl/shs_pkg.sv
// Package for the SHA-256 stream hasher: types, round constants, helper functions.
package shs_pkg;

	localparam int WordW   = 32;
	localparam int Rounds  = 64;
	localparam int Words   = 8;
	localparam int LenW    = 61;
	localparam int FillW   = 6;

	localparam logic [7:0]       PadByte   = 8'h80;
	localparam logic [7:0]       ZeroByte  = 8'h00;
	localparam logic [FillW-1:0] FillLast  = 6'd63;
	localparam logic [FillW-1:0] FillLenAt = 6'd56;
	localparam logic [5:0]       RoundLast = 6'd63;

	localparam logic [WordW-1:0] K_TAB [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WordW-1:0] H_INIT [Words] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// working variables a..h
	typedef struct packed {
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic [WordW-1:0] c;
		logic [WordW-1:0] d;
		logic [WordW-1:0] e;
		logic [WordW-1:0] f;
		logic [WordW-1:0] g;
		logic [WordW-1:0] h;
	} round_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_DONE
	} state_t;

	function automatic logic [WordW-1:0] sig0(input logic [WordW-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WordW-1:0] sig1(input logic [WordW-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage

FILE: rtl/shs_if.sv
// Handshake interfaces for the message byte beats and the digest word beats.
interface shs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, output data_byte, output has_byte, output last, input ready);
	modport sink (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

interface shs_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        word_last;
	logic        too_long;

	modport source (output valid, output digest_word, output word_last, output too_long,
		input ready);
	modport sink (input valid, input digest_word, input word_last, input too_long,
		output ready);
endinterface

FILE: rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: byte gathering, padding, round sequencer, digest out.
// Byte beats are taken one per cycle while a block fills; the 64th byte of a block starts a
// compression (64 rounds on one shared round unit, then one add), input stalled.
// A last beat adds a pad byte, zero bytes, the 64-bit length and one or two
// compressions; the digest leaves as 8 word beats from an output buffer, so the next
// message may start filling while they drain.
// Reset (arst_n low, asynchronous) clears control, loads the initial hash; no clearing pass.
module sha256_stream_hasher
	import shs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	shs_byte_if.sink     msg,
	shs_digest_if.source digest
);

	state_t state_q, state_d;

	// block buffer and message schedule share one window; [15] is the oldest word
	logic [15:0][WordW-1:0] win_q;
	logic [WordW-1:0]       hash_q [Words];
	round_t                 regs_q;
	logic [FillW-1:0]       fill_q;
	logic [LenW-1:0]        byte_cnt_q;
	logic                   ovf_q;
	logic [5:0]             round_q;
	logic                   pend_last_q;   // last beat came with the byte that filled a block
	logic                   pad_q;         // padding spilled into an extra block
	logic                   final_q;       // the running compression ends the message

	// digest output buffer
	logic [WordW-1:0]       out_q [Words];
	logic [3:0]             out_cnt_q;
	logic                   too_long_q;

	logic                   in_acc;
	logic                   out_acc;
	logic                   shift_en;
	logic [7:0]             shift_byte;
	logic                   len_en;
	logic                   comp_start;
	logic                   done_load;
	logic [63:0]            len_bits;
	round_t                 hash_st;
	round_t                 regs_nxt;
	logic [WordW-1:0]       w_new;

	assign in_acc   = msg.valid & msg.ready;
	assign out_acc  = digest.valid & digest.ready;
	assign len_bits = {byte_cnt_q, 3'b000};
	assign hash_st  = {hash_q[0], hash_q[1], hash_q[2], hash_q[3],
		hash_q[4], hash_q[5], hash_q[6], hash_q[7]};

	shs_round u_round (
		.cur   (regs_q),
		.k     (K_TAB[round_q]),
		.win   (win_q),
		.nxt   (regs_nxt),
		.w_new (w_new)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (msg.has_byte && fill_q == FillLast) begin
						state_d = ST_ROUND;
					end else if (msg.last) begin
						state_d = ST_PAD80;
					end
				end
			end
			ST_PAD80: begin
				state_d = (fill_q == FillLast) ? ST_ROUND : ST_ZERO;
			end
			ST_ZERO: begin
				if (fill_q == FillLenAt) begin
					state_d = ST_LEN;
				end else if (fill_q == FillLast) begin
					state_d = ST_ROUND;
				end
			end
			ST_LEN: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == RoundLast) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				priority if (final_q) begin
					state_d = ST_DONE;
				end else if (pad_q) begin
					state_d = ST_ZERO;
				end else if (pend_last_q) begin
					state_d = ST_PAD80;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (out_cnt_q == 4'd0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		msg.ready  = 1'b0;
		shift_en   = 1'b0;
		shift_byte = ZeroByte;
		len_en     = 1'b0;
		comp_start = 1'b0;
		done_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg.ready  = 1'b1;
				shift_en   = in_acc & msg.has_byte;
				shift_byte = msg.data_byte;
				comp_start = in_acc & msg.has_byte & (fill_q == FillLast);
			end
			ST_PAD80: begin
				shift_en   = 1'b1;
				shift_byte = PadByte;
				comp_start = (fill_q == FillLast);
			end
			ST_ZERO: begin
				shift_en   = (fill_q != FillLenAt);
				comp_start = (fill_q == FillLast);
			end
			ST_LEN: begin
				len_en     = 1'b1;
				comp_start = 1'b1;
			end
			ST_DONE: begin
				done_load = (out_cnt_q == 4'd0);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			byte_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			round_q     <= '0;
			pend_last_q <= 1'b0;
			pad_q       <= 1'b0;
			final_q     <= 1'b0;
			out_cnt_q   <= '0;
			for (int i = 0; i < Words; i++) begin
				hash_q[i] <= H_INIT[i];
			end
		end else begin
			state_q <= state_d;

			if (shift_en) begin
				fill_q <= fill_q + 1'b1;   // wraps to zero on a full block
			end
			if (len_en) begin
				fill_q <= '0;
			end

			if (state_q == ST_IDLE && in_acc) begin
				if (msg.has_byte) begin
					byte_cnt_q <= byte_cnt_q + 1'b1;
					if (&byte_cnt_q) begin
						ovf_q <= 1'b1;
					end
					if (fill_q == FillLast) begin
						pend_last_q <= msg.last;
					end
				end
			end

			if ((state_q == ST_PAD80 || state_q == ST_ZERO) && fill_q == FillLast) begin
				pad_q <= 1'b1;
			end
			if (len_en) begin
				pad_q   <= 1'b0;
				final_q <= 1'b1;
			end
			if (state_q == ST_ADD && !final_q && !pad_q) begin
				pend_last_q <= 1'b0;
			end

			if (comp_start) begin
				round_q <= '0;
			end else if (state_q == ST_ROUND) begin
				round_q <= round_q + 1'b1;
			end

			if (state_q == ST_ADD) begin
				hash_q[0] <= hash_q[0] + regs_q.a;
				hash_q[1] <= hash_q[1] + regs_q.b;
				hash_q[2] <= hash_q[2] + regs_q.c;
				hash_q[3] <= hash_q[3] + regs_q.d;
				hash_q[4] <= hash_q[4] + regs_q.e;
				hash_q[5] <= hash_q[5] + regs_q.f;
				hash_q[6] <= hash_q[6] + regs_q.g;
				hash_q[7] <= hash_q[7] + regs_q.h;
			end

			// digest handed to the output buffer, hasher restarts
			if (done_load) begin
				out_cnt_q  <= 4'd8;
				byte_cnt_q <= '0;
				ovf_q      <= 1'b0;
				final_q    <= 1'b0;
				for (int i = 0; i < Words; i++) begin
					hash_q[i] <= H_INIT[i];
				end
			end else if (out_acc) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (shift_en) begin
			// whole window moves up one byte, new byte in the low end
			win_q <= {win_q[15][23:0], win_q[14:0], shift_byte};
		end
		if (len_en) begin
			win_q <= {win_q[13:0], len_bits};
		end
		if (state_q == ST_ROUND) begin
			win_q  <= {win_q[14:0], w_new};
			regs_q <= regs_nxt;
		end
		if (comp_start) begin
			regs_q <= hash_st;
		end

		if (done_load) begin
			too_long_q <= ovf_q;
			for (int i = 0; i < Words; i++) begin
				out_q[i] <= hash_q[i];
			end
		end else if (out_acc) begin
			for (int i = 0; i < Words - 1; i++) begin
				out_q[i] <= out_q[i+1];
			end
		end
	end

	assign digest.valid       = (out_cnt_q != 4'd0);
	assign digest.digest_word = out_q[0];
	assign digest.word_last   = (out_cnt_q == 4'd1);
	assign digest.too_long    = too_long_q;

endmodule

FILE: rtl/shs_round.sv
// One SHA-256 compression round plus the next message schedule word.
module shs_round
	import shs_pkg::*;
(
	input  round_t                 cur,
	input  logic [WordW-1:0]       k,
	input  logic [15:0][WordW-1:0] win,
	output round_t                 nxt,
	output logic [WordW-1:0]       w_new
);

	logic [WordW-1:0] w;
	logic [WordW-1:0] ch;
	logic [WordW-1:0] maj;
	logic [WordW-1:0] t1;
	logic [WordW-1:0] t2;

	// win[15] is the oldest word, i.e. W[t]
	assign w     = win[15];
	assign w_new = win[15] + sig0(win[14]) + win[6] + sig1(win[1]);

	assign ch  = (cur.e & cur.f) ^ (~cur.e & cur.g);
	assign maj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
	assign t1  = cur.h + bsig1(cur.e) + ch + k + w;
	assign t2  = bsig0(cur.a) + maj;

	always_comb begin
		nxt.h = cur.g;
		nxt.g = cur.f;
		nxt.f = cur.e;
		nxt.e = cur.d + t1;
		nxt.d = cur.c;
		nxt.c = cur.b;
		nxt.b = cur.a;
		nxt.a = t1 + t2;
	end

endmodule
